FILE: rtl/splm_pkg.sv
// Shared types, field widths and codes for the slot pool lease manager.
// No dependencies; every other file in rtl/ except splm_ram imports this package.
package splm_pkg;

  localparam int DEF_MAX_SLOTS  = 16;
  localparam int DEF_GEN_BITS   = 32;
  localparam int DEF_COUNT_BITS = 8;

  localparam int OPCODE_W     = 2;
  localparam int IDX_W        = 4;
  localparam int TAG_W        = 32;
  localparam int SIZE_W       = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_COUNT_W = 5;
  localparam int CAPACITY_W   = 32;
  localparam int SLOT_ST_W    = 2;

  localparam int IN_FIELDS_W  = IDX_W + TAG_W + SIZE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = OPCODE_W;
  localparam int OUT_FIELDS_W = STATUS_W + IDX_W + TAG_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_CAPACITY = 1'b1;

  localparam logic [SLOT_COUNT_W-1:0] RST_SLOT_COUNT    = 5'd16;
  localparam logic [CAPACITY_W-1:0]   RST_SLOT_CAPACITY = 32'd65536;

  localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_COMMIT  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LEASE   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd3;

  localparam logic [STATUS_W-1:0] RC_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] RC_NOFREE = 3'd1;
  localparam logic [STATUS_W-1:0] RC_BADIDX = 3'd2;
  localparam logic [STATUS_W-1:0] RC_STATE  = 3'd3;
  localparam logic [STATUS_W-1:0] RC_GEN    = 3'd4;
  localparam logic [STATUS_W-1:0] RC_SIZE   = 3'd5;
  localparam logic [STATUS_W-1:0] RC_FULL   = 3'd6;

  localparam logic [SLOT_ST_W-1:0] SS_AVAILABLE = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SS_WRITING   = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SS_READABLE  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic norm_step;
  } dp_cmd_t;

  typedef struct packed {
    logic start_high;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/splm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module splm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  wr_addr,
  wr_data,
  rd_addr,
  rd_data
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic              clk;
  input  logic              we;
  input  logic [ADDR_W-1:0] wr_addr;
  input  logic [WIDTH-1:0]  wr_data;
  input  logic [ADDR_W-1:0] rd_addr;
  output logic [WIDTH-1:0]  rd_data;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/splm_ctrl.sv
// Controller state machine for the slot pool lease manager.
// Depends on splm_pkg for the command and status structs.
module splm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  splm_pkg::dp_stat_t stat,
  output splm_pkg::dp_cmd_t  cmd
);
  import splm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_NORM = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE) && !stat.start_high;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (stat.start_high) begin
          state_next = S_NORM;
        end else if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NORM: begin
        if (stat.start_high) begin
          cmd.norm_step = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/splm_datapath.sv
// Datapath: configuration registers, slot table, rotating free-slot scan,
// check logic and output register. Depends on splm_pkg and splm_ram.
module splm_datapath #(
  parameter int MAX_SLOTS  = splm_pkg::DEF_MAX_SLOTS,
  parameter int GEN_BITS   = splm_pkg::DEF_GEN_BITS,
  parameter int COUNT_BITS = splm_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [splm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [splm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [splm_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [splm_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [splm_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  splm_pkg::dp_cmd_t                   cmd,
  output splm_pkg::dp_stat_t                  stat
);
  import splm_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int GEN_LO = SLOT_ST_W;
  localparam int CNT_LO = GEN_LO + GEN_BITS;
  localparam int SZ_LO  = CNT_LO + COUNT_BITS;
  localparam int WORD_W = SZ_LO + SIZE_W;

  logic [SLOT_COUNT_W-1:0] slot_count;
  logic [CAPACITY_W-1:0]   slot_capacity;
  logic [SLOT_W-1:0]       cursor;
  logic [SLOT_W-1:0]       start;
  logic [MAX_SLOTS-1:0]    busy;
  logic [MAX_SLOTS-1:0]    valid;

  logic [OPCODE_W-1:0] op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [TAG_W-1:0]    tag_q;
  logic [SIZE_W-1:0]   size_q;
  logic                found_q;
  logic [SLOT_W-1:0]   addr_q;
  logic                rd_valid;

  logic [SLOT_COUNT_W-1:0] n;
  logic [OPCODE_W-1:0]     in_op;
  logic [IDX_W-1:0]        in_idx;
  logic [MAX_SLOTS-1:0]    free;
  logic [MAX_SLOTS-1:0]    upper;
  logic                    scan_found;
  logic [SLOT_W-1:0]       hi_slot;
  logic [SLOT_W-1:0]       lo_slot;
  logic [SLOT_W-1:0]       scan_slot;
  logic [SLOT_W-1:0]       rd_addr;
  logic [WORD_W-1:0]       ram_rd;
  logic [WORD_W-1:0]       entry;
  logic [WORD_W-1:0]       wr_word;

  logic [SLOT_ST_W-1:0]  e_state;
  logic [GEN_BITS-1:0]   e_gen;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [SIZE_W-1:0]     e_size;
  logic [SLOT_ST_W-1:0]  new_state;
  logic [GEN_BITS-1:0]   new_gen;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [SIZE_W-1:0]     new_size;
  logic                  wr_en;
  logic                  gen_ok;
  logic                  idx_bad;
  logic [STATUS_W-1:0]   status;
  logic [IDX_W-1:0]      out_slot;
  logic [TAG_W-1:0]      out_gen;
  logic [31:0]           cursor_inc;

  assign n = (32'(slot_count) > MAX_SLOTS) ? SLOT_COUNT_W'(MAX_SLOTS) : slot_count;

  assign in_op  = s_tuser;
  assign in_idx = s_tdata[IDX_W-1:0];

  assign stat.start_high = (n != '0) && (32'(start) >= 32'(n));
  assign stat.out_free   = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free[i]  = !busy[i] && (i < 32'(n));
      upper[i] = free[i] && (i >= 32'(start));
    end
  end

  always_comb begin
    hi_slot = '0;
    lo_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (upper[i]) hi_slot = SLOT_W'(i);
      if (free[i])  lo_slot = SLOT_W'(i);
    end
    scan_found = |free;
    scan_slot  = (|upper) ? hi_slot : lo_slot;
  end

  assign rd_addr = !cmd.load ? addr_q :
                   (in_op == OP_ACQUIRE) ? scan_slot : SLOT_W'(in_idx);

  splm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (cmd.exec && wr_en),
    .wr_addr (addr_q),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  assign entry   = rd_valid ? ram_rd : '0;
  assign e_state = entry[SLOT_ST_W-1:0];
  assign e_gen   = entry[CNT_LO-1:GEN_LO];
  assign e_cnt   = entry[SZ_LO-1:CNT_LO];
  assign e_size  = entry[WORD_W-1:SZ_LO];

  assign gen_ok     = (e_gen == GEN_BITS'(tag_q));
  assign idx_bad    = (32'(idx_q) >= 32'(n));
  assign wr_word    = {new_size, new_cnt, new_gen, new_state};
  assign cursor_inc = 32'(addr_q) + 32'd1;

  always_comb begin
    status    = RC_OK;
    wr_en     = 1'b0;
    new_state = e_state;
    new_gen   = e_gen;
    new_cnt   = e_cnt;
    new_size  = e_size;
    out_slot  = idx_q;
    out_gen   = tag_q;
    if (op_q == OP_ACQUIRE) begin
      out_slot = '0;
      out_gen  = '0;
      if (!found_q) begin
        status = RC_NOFREE;
      end else begin
        new_gen   = e_gen + GEN_BITS'(1);
        new_state = SS_WRITING;
        new_size  = '0;
        wr_en     = 1'b1;
        out_slot  = IDX_W'(addr_q);
        out_gen   = TAG_W'(new_gen);
      end
    end else if (idx_bad) begin
      status = RC_BADIDX;
    end else begin
      case (op_q)
        OP_COMMIT: begin
          if (e_state != SS_WRITING) begin
            status = RC_STATE;
          end else if (!gen_ok) begin
            status = RC_GEN;
          end else if (size_q > slot_capacity) begin
            status = RC_SIZE;
          end else begin
            new_state = SS_READABLE;
            new_size  = size_q;
            wr_en     = 1'b1;
          end
        end
        OP_LEASE: begin
          if (e_state != SS_READABLE) begin
            status = RC_STATE;
          end else if (!gen_ok) begin
            status = RC_GEN;
          end else if (e_cnt == '1) begin
            status = RC_FULL;
          end else begin
            new_cnt = e_cnt + COUNT_BITS'(1);
            wr_en   = 1'b1;
          end
        end
        default: begin
          if (!gen_ok) begin
            status = RC_GEN;
          end else begin
            if (e_cnt != '0) new_cnt = e_cnt - COUNT_BITS'(1);
            wr_en = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= RST_SLOT_COUNT;
      slot_capacity <= RST_SLOT_CAPACITY;
      cursor        <= '0;
      start         <= '0;
      busy          <= '0;
      valid         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT: begin
            slot_count <= cfg_data[SLOT_COUNT_W-1:0];
            start      <= cursor;
          end
          CFG_SLOT_CAPACITY: slot_capacity <= cfg_data[CAPACITY_W-1:0];
          default: ;
        endcase
      end else if (cmd.norm_step) begin
        start <= SLOT_W'(32'(start) - 32'(n));
      end
      if (cmd.exec && wr_en) begin
        valid[addr_q] <= 1'b1;
        busy[addr_q]  <= (new_state == SS_WRITING) || (new_cnt != '0);
        if (op_q == OP_ACQUIRE) begin
          cursor <= (cursor_inc == 32'(n)) ? '0 : SLOT_W'(cursor_inc);
          start  <= (cursor_inc == 32'(n)) ? '0 : SLOT_W'(cursor_inc);
        end
      end
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_op;
      idx_q    <= in_idx;
      tag_q    <= s_tdata[IDX_W+TAG_W-1:IDX_W];
      size_q   <= s_tdata[IN_FIELDS_W-1:IDX_W+TAG_W];
      found_q  <= scan_found;
      addr_q   <= rd_addr;
      rd_valid <= valid[rd_addr];
    end
    if (cmd.exec) begin
      m_tdata <= OUT_TDATA_W'({out_gen, out_slot, status});
    end
  end

endmodule

FILE: rtl/slot_pool_lease_manager_core.sv
// Slot pool lease manager, top level: controller plus datapath.
// A request's table read is registered at the input transfer; the check, table write and result
// register follow in S_EXEC, which waits while an unaccepted result is held. No new request is taken until then.
// A slot_count write re-derives the scan start by subtraction, with s_tready low until it is done.
// Reset (rst, synchronous, active high) empties all slots at once through per-slot valid bits.
// Depends on splm_pkg, splm_ctrl, splm_datapath and splm_ram.
module slot_pool_lease_manager_core #(
  parameter int MAX_SLOTS  = splm_pkg::DEF_MAX_SLOTS,
  parameter int GEN_BITS   = splm_pkg::DEF_GEN_BITS,
  parameter int COUNT_BITS = splm_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [splm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [splm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot_index[3:0], gen_tag[35:4], commit_size[67:36], zero fill above
  input  logic [splm_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [splm_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status_code[2:0], granted_slot[6:3], granted_gen[38:7], zero fill above
  output logic [splm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import splm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  splm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  splm_datapath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .GEN_BITS   (GEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: rtl/splm_checker.sv
// Port-level checks for slot_pool_lease_manager_core, bound to the top level.
// Depends on splm_pkg.
module splm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [splm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import splm_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STATUS_W-1:0] <= RC_FULL))
    else $error("status code out of range");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[STATUS_W-1:0] == RC_NOFREE))
      |-> (m_tdata[OUT_FIELDS_W-1:STATUS_W] == '0))
    else $error("failed acquire returned nonzero slot or generation");

endmodule

bind slot_pool_lease_manager_core splm_checker u_splm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/slot_pool_lease_checker.sv
// Watches the config port and both stream channels of the slot pool lease manager,
// predicts every result from its own model of the pool and compares field by field.
// Depends on splm_pkg.
module slot_pool_lease_checker
  import splm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // slot_index[3:0], gen_tag[35:4], commit_size[67:36], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // status_code[2:0], granted_slot[6:3], granted_gen[38:7], zero fill above
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     mismatches,
  output int                     pending_count
);

  localparam int POOL_DEPTH = DEF_MAX_SLOTS;
  localparam logic [DEF_COUNT_BITS-1:0] READERS_MAX = '1;

  typedef struct packed {
    logic [TAG_W-1:0]    gen;
    logic [IDX_W-1:0]    slot;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic [SLOT_ST_W-1:0]      slot_phase [POOL_DEPTH];
  logic [DEF_GEN_BITS-1:0]   slot_gen   [POOL_DEPTH];
  logic [DEF_COUNT_BITS-1:0] readers    [POOL_DEPTH];
  logic [SIZE_W-1:0]         filled     [POOL_DEPTH];
  int unsigned               cursor;
  logic [SLOT_COUNT_W-1:0]   count_reg;
  logic [CAPACITY_W-1:0]     cap_reg;

  grant_t pending_grants [$];
  int     fail_tally = 0;
  grant_t got;
  grant_t want;
  grant_t fresh;

  function automatic grant_t apply_request(input logic [OPCODE_W-1:0] op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [SIZE_W-1:0] size);
    int unsigned n;
    int unsigned i;
    int unsigned off;
    bit          found;
    grant_t      g;
    n = (count_reg > POOL_DEPTH) ? POOL_DEPTH : count_reg;
    g.status = RC_OK;
    g.slot = idx;
    g.gen = tag;
    found = 1'b0;
    if (op == OP_ACQUIRE) begin
      g.status = RC_NOFREE;
      g.slot = '0;
      g.gen = '0;
      for (off = 0; off < n && !found; off++) begin
        i = (cursor % n + off) % n;
        if (slot_phase[i] != SS_WRITING && readers[i] == 0) begin
          slot_gen[i] = slot_gen[i] + 1'b1;
          slot_phase[i] = SS_WRITING;
          filled[i] = '0;
          cursor = (i + 1) % n;
          g.status = RC_OK;
          g.slot = IDX_W'(i);
          g.gen = slot_gen[i];
          found = 1'b1;
        end
      end
    end else if (idx >= n) begin
      g.status = RC_BADIDX;
    end else if (op == OP_COMMIT) begin
      if (slot_phase[idx] != SS_WRITING) g.status = RC_STATE;
      else if (slot_gen[idx] != tag) g.status = RC_GEN;
      else if (size > cap_reg) g.status = RC_SIZE;
      else begin
        slot_phase[idx] = SS_READABLE;
        filled[idx] = size;
      end
    end else if (op == OP_LEASE) begin
      if (slot_phase[idx] != SS_READABLE) g.status = RC_STATE;
      else if (slot_gen[idx] != tag) g.status = RC_GEN;
      else if (readers[idx] >= READERS_MAX) g.status = RC_FULL;
      else readers[idx] = readers[idx] + 1'b1;
    end else begin
      if (slot_gen[idx] != tag) g.status = RC_GEN;
      else if (readers[idx] != 0) readers[idx] = readers[idx] - 1'b1;
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < POOL_DEPTH; k++) begin
        slot_phase[k] = SS_AVAILABLE;
        slot_gen[k] = '0;
        readers[k] = '0;
        filled[k] = '0;
      end
      cursor = 0;
      count_reg = RST_SLOT_COUNT;
      cap_reg = RST_SLOT_CAPACITY;
      pending_grants.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT:    count_reg = cfg_data[SLOT_COUNT_W-1:0];
          CFG_SLOT_CAPACITY: cap_reg = cfg_data[CAPACITY_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = grant_t'(m_tdata[OUT_FIELDS_W-1:0]);
        if (pending_grants.size() == 0) begin
          $error("unexpected result: status_code %0d granted_slot %0d granted_gen %0h",
                 got.status, got.slot, got.gen);
          fail_tally++;
        end else begin
          want = pending_grants.pop_front();
          if (got.status !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, got.status);
            fail_tally++;
          end
          if (got.slot !== want.slot) begin
            $error("granted_slot: expected %0d, got %0d", want.slot, got.slot);
            fail_tally++;
          end
          if (got.gen !== want.gen) begin
            $error("granted_gen: expected %0h, got %0h", want.gen, got.gen);
            fail_tally++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = apply_request(s_tuser,
                              s_tdata[IDX_W-1:0],
                              s_tdata[IDX_W +: TAG_W],
                              s_tdata[IDX_W+TAG_W +: SIZE_W]);
        pending_grants = {pending_grants, fresh};
      end
    end
    mismatches <= fail_tally;
    pending_count <= pending_grants.size();
  end

endmodule

FILE: dv/slot_pool_lease_manager_core_tb.sv
// Top of the slot pool lease manager bench: clock, reset, config writes, request
// stimulus with bursty sending and a stalling receiver, and the final verdict.
// Depends on splm_pkg, slot_pool_lease_manager_core and slot_pool_lease_checker.
module slot_pool_lease_manager_core_tb;
  import splm_pkg::*;

  localparam int POOL_DEPTH    = DEF_MAX_SLOTS;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  typedef enum int {SEEK_WRITING, SEEK_READABLE, SEEK_LEASED} seek_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatches;
  int pending_count;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  logic [SLOT_COUNT_W-1:0] cur_count = RST_SLOT_COUNT;
  logic [CAPACITY_W-1:0]   cur_cap = RST_SLOT_CAPACITY;

  // what the stimulus has learned about the pool from returned results
  logic [TAG_W-1:0]    known_gen [POOL_DEPTH];
  bit                  writing   [POOL_DEPTH];
  bit                  readable  [POOL_DEPTH];
  int                  leased    [POOL_DEPTH];
  logic [OPCODE_W-1:0] sent_ops  [$];
  bit                  last_acq_ok = 1'b0;
  logic [IDX_W-1:0]    last_acq_slot = '0;

  logic [OPCODE_W-1:0] seen_op;
  logic [STATUS_W-1:0] seen_status;
  logic [IDX_W-1:0]    seen_slot;
  logic [TAG_W-1:0]    seen_gen;

  logic [OPCODE_W-1:0] req_op;
  logic [IDX_W-1:0]    req_idx;
  logic [TAG_W-1:0]    req_tag;
  logic [SIZE_W-1:0]   req_size;
  logic [IDX_W-1:0]    storm_slot;
  logic [TAG_W-1:0]    storm_gen;

  slot_pool_lease_manager_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  slot_pool_lease_checker lease_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** slot_pool_lease_manager_core: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < POOL_DEPTH; k++) begin
      known_gen[k] = '0;
      writing[k] = 1'b0;
      readable[k] = 1'b0;
      leased[k] = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && sent_ops.size() != 0) begin
      seen_op = sent_ops.pop_front();
      seen_status = m_tdata[STATUS_W-1:0];
      seen_slot = m_tdata[STATUS_W +: IDX_W];
      seen_gen = m_tdata[STATUS_W+IDX_W +: TAG_W];
      if (seen_op == OP_ACQUIRE) begin
        last_acq_ok = (seen_status == RC_OK);
        last_acq_slot = seen_slot;
      end
      if (seen_status == RC_OK) begin
        case (seen_op)
          OP_ACQUIRE: begin
            known_gen[seen_slot] = seen_gen;
            writing[seen_slot] = 1'b1;
            readable[seen_slot] = 1'b0;
            leased[seen_slot] = 0;
          end
          OP_COMMIT: begin
            writing[seen_slot] = 1'b0;
            readable[seen_slot] = 1'b1;
          end
          OP_LEASE: leased[seen_slot]++;
          default: if (leased[seen_slot] != 0) leased[seen_slot]--;
        endcase
      end
    end
  end

  // receiver: changing stall patterns, one long hold-off on request
  initial begin
    int mode;
    int span;
    wait (!rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 1) != 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic offer_request(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic [TAG_W-1:0] tag, input logic [SIZE_W-1:0] size);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, size, tag, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_ops = {sent_ops, op};
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic settle_pool();
    if (burst_left != 0) s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool(input logic [SLOT_COUNT_W-1:0] count,
                          input logic [CAPACITY_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SLOT_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= CFG_SLOT_CAPACITY;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_count = count;
    cur_cap = cap;
  endtask

  function automatic int slots_live();
    return (cur_count > POOL_DEPTH) ? POOL_DEPTH : cur_count;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot(input seek_t seek);
    int n;
    int start;
    int i;
    bit hit;
    n = slots_live();
    if (n == 0) return IDX_W'($urandom_range(0, POOL_DEPTH - 1));
    start = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      i = (start + k) % n;
      case (seek)
        SEEK_WRITING:  hit = writing[i];
        SEEK_READABLE: hit = readable[i];
        default:       hit = (leased[i] != 0);
      endcase
      if (hit) return IDX_W'(i);
    end
    return IDX_W'(start);
  endfunction

  function automatic logic [OPCODE_W-1:0] OP_OPCODE_ANY();
    return OPCODE_W'($urandom_range(0, 3));
  endfunction

  task automatic make_request(output logic [OPCODE_W-1:0] op, output logic [IDX_W-1:0] idx,
                              output logic [TAG_W-1:0] tag, output logic [SIZE_W-1:0] size);
    int pick;
    int n;
    n = slots_live();
    op = OP_ACQUIRE;
    idx = IDX_W'($urandom);
    tag = $urandom;
    size = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op = OP_OPCODE_ANY();
    end else if (pick >= 30) begin
      if (pick < 55) begin
        op = OP_COMMIT;
        idx = pick_slot(SEEK_WRITING);
      end else if (pick < 80) begin
        op = OP_LEASE;
        idx = pick_slot(SEEK_READABLE);
      end else begin
        op = OP_RELEASE;
        idx = pick_slot(SEEK_LEASED);
      end
      if ($urandom_range(0, 9) != 0) tag = known_gen[idx];
      if (n < POOL_DEPTH && $urandom_range(0, 19) == 0) idx = IDX_W'($urandom_range(n, 15));
      if (op == OP_COMMIT) begin
        case ($urandom_range(0, 5))
          0: size = cur_cap;
          1: size = (cur_cap == '1) ? $urandom : cur_cap + 1'b1;
          2: size = $urandom;
          default: size = $urandom_range(0, cur_cap);
        endcase
      end
    end
  endtask

  task automatic run_phase(input logic [SLOT_COUNT_W-1:0] count,
                           input logic [CAPACITY_W-1:0] cap, input int items);
    settle_pool();
    set_pool(count, cap);
    repeat (items) begin
      make_request(req_op, req_idx, req_tag, req_size);
      offer_request(req_op, req_idx, req_tag, req_size);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: commit checks, lease checks, release corner cases
    offer_request(OP_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(OP_COMMIT,  4'd0,  32'd1, 32'd65537);
    offer_request(OP_COMMIT,  4'd0,  32'd2, 32'd0);
    offer_request(OP_COMMIT,  4'd0,  32'd1, 32'd65536);
    offer_request(OP_COMMIT,  4'd0,  32'd1, 32'd0);
    offer_request(OP_LEASE,   4'd0,  32'd1, 32'd0);
    offer_request(OP_LEASE,   4'd1,  32'd0, 32'd0);
    offer_request(OP_LEASE,   4'd0,  32'd0, 32'd0);
    offer_request(OP_ACQUIRE, 4'd0,  32'd0, 32'd0);
    offer_request(OP_RELEASE, 4'd0,  32'd1, 32'd0);
    offer_request(OP_RELEASE, 4'd0,  32'd1, 32'd0);
    offer_request(OP_RELEASE, 4'd3,  32'd0, 32'd0);
    offer_request(OP_RELEASE, 4'd3,  32'hFFFF_FFFF, 32'd0);
    offer_request(OP_COMMIT,  4'd15, 32'd0, 32'hFFFF_FFFF);
    offer_request(OP_LEASE,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // single slot, largest capacity: scan start wraps, pool runs dry
    settle_pool();
    set_pool(5'd1, 32'hFFFF_FFFF);
    offer_request(OP_ACQUIRE, 4'd0, 32'd0, 32'd0);
    offer_request(OP_ACQUIRE, 4'd0, 32'd0, 32'd0);
    offer_request(OP_COMMIT,  4'd1, 32'd1, 32'd0);
    offer_request(OP_COMMIT,  4'd0, 32'd2, 32'hFFFF_FFFF);

    // no slots in use
    settle_pool();
    set_pool(5'd0, 32'd0);
    offer_request(OP_ACQUIRE, 4'd0, 32'd0, 32'd0);
    offer_request(OP_LEASE,   4'd0, 32'd2, 32'd0);
    offer_request(OP_RELEASE, 4'd0, 32'd2, 32'd0);

    // count above pool depth, zero capacity
    settle_pool();
    set_pool(5'd31, 32'd0);
    offer_request(OP_ACQUIRE, 4'd0, 32'd0, 32'd0);
    offer_request(OP_COMMIT,  4'd0, 32'd3, 32'd1);
    offer_request(OP_COMMIT,  4'd0, 32'd3, 32'd0);

    // fill one slot's reader count past its maximum while the receiver holds off
    settle_pool();
    set_pool(RST_SLOT_COUNT, RST_SLOT_CAPACITY);
    offer_request(OP_ACQUIRE, 4'd0, 32'd0, 32'd0);
    settle_pool();
    if (last_acq_ok) begin
      storm_slot = last_acq_slot;
      storm_gen = known_gen[storm_slot];
      offer_request(OP_COMMIT, storm_slot, storm_gen, $urandom_range(0, 65536));
      hold_req = 1'b1;
      repeat (257) offer_request(OP_LEASE, storm_slot, storm_gen, $urandom);
      repeat (3) offer_request(OP_RELEASE, storm_slot, storm_gen, $urandom);
      offer_request(OP_LEASE, storm_slot, storm_gen, $urandom);
    end

    run_phase(5'd16, 32'd65536, 70);
    run_phase(5'd4, 32'd1000, 70);
    run_phase(5'd1, 32'hFFFF_FFFF, 70);
    run_phase(5'd20, 32'd1, 70);
    run_phase(SLOT_COUNT_W'($urandom_range(2, 15)), $urandom, 70);
    run_phase(5'd0, 32'd5, 20);

    settle_pool();
    if (mismatches == 0) begin
      $display("** slot_pool_lease_manager_core: PASSED **");
    end else begin
      $display("** slot_pool_lease_manager_core: FAILED **");
    end
    $finish;
  end

endmodule
